// File: rtl/wllf_pkg.sv
// ----------------------------------------------------------------------------
// wllf_pkg
// Shared types and constants of the link-flip proposal engine.
// ----------------------------------------------------------------------------
`default_nettype none

package wllf_pkg;

  localparam int LOG_W = 48;
  localparam int VIS_W = 32;

  localparam logic [LOG_W-1:0] LOG_MAX     = {LOG_W{1'b1}};
  localparam logic [VIS_W-1:0] VIS_MAX     = {VIS_W{1'b1}};
  localparam logic [LOG_W-1:0] LOG_INC_RST = 48'h0001_0000_0000;

  // action codes
  localparam logic [1:0] ACT_UPDATE = 2'd0;
  localparam logic [1:0] ACT_FLIP   = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [11:0]      site;
    logic [1:0]       direction;
    logic [LOG_W-1:0] neg_log_draw;
    logic [15:0]      bin;
  } in_req_t;

  typedef struct packed {
    logic             accepted;
    logic [15:0]      energy_index;
    logic [LOG_W-1:0] log_density;
    logic [VIS_W-1:0] visits;
  } out_rsp_t;

  // plane of the plaquette spanned by two directions (xy,xz,xt,yz,yt,zt)
  function automatic logic [2:0] plane_of(input logic [1:0] mu, input logic [1:0] nu);
    logic [2:0] p;
    p = 3'd0;
    case ({mu, nu})
      4'b0001, 4'b0100: p = 3'd0;
      4'b0010, 4'b1000: p = 3'd1;
      4'b0011, 4'b1100: p = 3'd2;
      4'b0110, 4'b1001: p = 3'd3;
      4'b0111, 4'b1101: p = 3'd4;
      4'b1011, 4'b1110: p = 3'd5;
      default:          p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// File: rtl/wllf_plaq_addr.sv
// ----------------------------------------------------------------------------
// wllf_plaq_addr
// Index of the k-th plaquette that holds a link, from site, coordinates and
// direction; odd k take the backward periodic neighbour.
// ----------------------------------------------------------------------------
`default_nettype none

module wllf_plaq_addr #(
  parameter int SIDE = 8
) (
  input  wire logic [$clog2(SIDE**4)-1:0]   site_i,
  input  wire logic [3:0][$clog2(SIDE)-1:0] coord_i,
  input  wire logic [1:0]                   dir_i,
  input  wire logic [2:0]                   k_i,
  output logic      [$clog2(6*SIDE**4)-1:0] addr_o
);

  localparam int NSITES = SIDE**4;
  localparam int SW     = $clog2(NSITES);
  localparam int PW     = $clog2(6*NSITES);
  localparam int DW     = $clog2(SIDE);

  logic [1:0]    j;
  logic [1:0]    nu;
  logic [SW-1:0] stride;
  logic [SW-1:0] nsite;
  logic [SW-1:0] s;
  logic [2:0]    p;

  // pick the k/2-th direction other than the link's own
  always_comb begin
    j  = k_i[2:1];
    nu = (j < dir_i) ? j : 2'(j + 2'd1);
    case (nu)
      2'd0:    stride = SW'(SIDE*SIDE*SIDE);
      2'd1:    stride = SW'(SIDE*SIDE);
      2'd2:    stride = SW'(SIDE);
      default: stride = SW'(1);
    endcase
  end

  // backward neighbour with wrap
  always_comb begin
    if (coord_i[nu] == DW'(0)) begin
      nsite = SW'(site_i + SW'(stride * SW'(SIDE-1)));
    end else begin
      nsite = SW'(site_i - stride);
    end
    s      = k_i[0] ? nsite : site_i;
    p      = wllf_pkg::plane_of(dir_i, nu);
    addr_o = PW'(PW'(s) * PW'(6) + PW'(p));
  end

endmodule

`default_nettype wire

// File: rtl/wang_landau_link_flip.sv
// ----------------------------------------------------------------------------
// wang_landau_link_flip
// Link-flip proposal engine with log-density and visit tables.
// ----------------------------------------------------------------------------
// One request at a time. An update runs through the coordinate digits, the
// reads of the link's six plaquettes, the target bin and the two
// log-density reads, the six plaquette writes when the flip is taken, then a
// table read and write-back, and then waits for the output handshake. All of
// it runs over single-port memories, one access per memory per cycle, which
// sets the rate. A forced flip skips the log-density reads. A histogram clear
// sweeps the visit table. After reset a clearing pass zeroes all memories; no
// request is taken meanwhile, configuration writes are.
`default_nettype none

module wang_landau_link_flip #(
  parameter int SIDE = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [wllf_pkg::LOG_W-1:0] cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire wllf_pkg::in_req_t          in_req_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output wllf_pkg::out_rsp_t              out_rsp_o
);

  localparam int NSITES  = SIDE**4;
  localparam int NLEVELS = 12*NSITES + 1;
  localparam int NPLAQ   = 6*NSITES;
  localparam int SW      = $clog2(NSITES);
  localparam int PW      = $clog2(NPLAQ);
  localparam int EW      = $clog2(NLEVELS);
  localparam int DW      = $clog2(SIDE);
  localparam int RK      = 20;
  localparam int RECIP   = (2**RK + SIDE - 1) / SIDE;
  localparam int LW      = wllf_pkg::LOG_W;
  localparam int VW      = wllf_pkg::VIS_W;

  typedef enum logic [10:0] {
    ST_CLEAR  = 11'b000_0000_0001,
    ST_IDLE   = 11'b000_0000_0010,
    ST_DIGIT  = 11'b000_0000_0100,
    ST_PRD    = 11'b000_0000_1000,
    ST_NB     = 11'b000_0001_0000,
    ST_LOGN   = 11'b000_0010_0000,
    ST_LOGO   = 11'b000_0100_0000,
    ST_DECIDE = 11'b000_1000_0000,
    ST_FLIP   = 11'b001_0000_0000,
    ST_TRD    = 11'b010_0000_0000,
    ST_TWR    = 11'b100_0000_0000
  } state_e;

  state_e                 state_q, state_d;
  wllf_pkg::in_req_t      req_q, req_d;
  logic [11:0]            rem_q, rem_d;
  logic [3:0][DW-1:0]     coord_q, coord_d;
  logic [2:0]             k_q, k_d;
  logic [2:0]             negs_q, negs_d;
  logic [5:0]             sbits_q, sbits_d;
  logic [EW-1:0]          nb_q, nb_d;
  logic [EW-1:0]          e_q, e_d;
  logic [EW-1:0]          rep_q, rep_d;
  logic [EW-1:0]          clr_q, clr_d;
  logic [LW-1:0]          lnew_q, lnew_d;
  logic [LW-1:0]          linc_q, linc_d;
  logic                   acc_q, acc_d;
  logic                   rep_ok_q, rep_ok_d;
  logic                   inc_q, inc_d;
  logic                   hist_only_q, hist_only_d;
  wllf_pkg::out_rsp_t     out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  // memories
  logic                   pl_mem [NPLAQ];
  logic [LW-1:0]          lg_mem [NLEVELS];
  logic [VW-1:0]          vs_mem [NLEVELS];
  logic [PW-1:0]          pl_addr;
  logic                   pl_we, pl_wdata, pl_rdata_q;
  logic [EW-1:0]          tb_addr;
  logic                   lg_we, vs_we;
  logic [LW-1:0]          lg_wdata, lg_rdata_q;
  logic [VW-1:0]          vs_wdata, vs_rdata_q;

  // datapath helpers
  logic [PW-1:0]          paddr;
  logic [32:0]            prod;
  logic [11:0]            quo;
  logic [11:0]            digit;
  logic [EW+1:0]          nbx;
  logic [LW:0]            dlog;
  logic                   d_le0;
  logic [LW:0]            lsum;
  logic [LW-1:0]          lg_new;
  logic [VW-1:0]          vs_new;

  wllf_plaq_addr #(.SIDE(SIDE)) u_paddr (
    .site_i  (SW'(req_q.site)),
    .coord_i (coord_q),
    .dir_i   (req_q.direction),
    .k_i     (k_q),
    .addr_o  (paddr)
  );

  // one digit of the site per cycle: quotient by reciprocal multiply
  always_comb begin
    prod  = 33'(rem_q) * 33'(RECIP);
    quo   = prod[RK+11:RK];
    digit = 12'(rem_q - 12'(quo * 12'(SIDE)));
  end

  // target bin, clamped
  always_comb begin
    nbx = (EW+2)'({2'b00, e_q} + (EW+2)'({negs_q, 2'b00}) - (EW+2)'(12));
    if (nbx[EW+1]) begin
      nb_d = '0;
    end else if (nbx > (EW+2)'(NLEVELS-1)) begin
      nb_d = EW'(NLEVELS-1);
    end else begin
      nb_d = nbx[EW-1:0];
    end
  end

  // acceptance and saturating updates
  always_comb begin
    dlog   = {1'b0, lnew_q} - {1'b0, lg_rdata_q};
    d_le0  = dlog[LW] || (dlog == '0);
    lsum   = {1'b0, lg_rdata_q} + {1'b0, linc_q};
    lg_new = lsum[LW] ? wllf_pkg::LOG_MAX : lsum[LW-1:0];
    vs_new = (vs_rdata_q == wllf_pkg::VIS_MAX) ? vs_rdata_q : VW'(vs_rdata_q + VW'(1));
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    rem_d       = rem_q;
    coord_d     = coord_q;
    k_d         = k_q;
    negs_d      = negs_q;
    sbits_d     = sbits_q;
    e_d         = e_q;
    rep_d       = rep_q;
    clr_d       = clr_q;
    lnew_d      = lnew_q;
    acc_d       = acc_q;
    rep_ok_d    = rep_ok_q;
    inc_d       = inc_q;
    hist_only_d = hist_only_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    linc_d      = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : linc_q;
    pl_addr     = paddr;
    pl_we       = 1'b0;
    pl_wdata    = 1'b0;
    tb_addr     = rep_q;
    lg_we       = 1'b0;
    vs_we       = 1'b0;
    lg_wdata    = '0;
    vs_wdata    = '0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        tb_addr  = clr_q;
        vs_we    = 1'b1;
        pl_addr  = PW'(clr_q);
        if (!hist_only_q) begin
          lg_we = 1'b1;
          pl_we = (32'(clr_q) < NPLAQ);
        end
        clr_d = EW'(clr_q + EW'(1));
        if (clr_q == EW'(NLEVELS-1)) begin
          clr_d = '0;
          if (hist_only_q) begin
            rep_d    = e_q;
            rep_ok_d = 1'b1;
            inc_d    = 1'b0;
            state_d  = ST_TRD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d    = in_req_i;
          rem_d    = in_req_i.site;
          k_d      = '0;
          negs_d   = '0;
          acc_d    = 1'b0;
          inc_d    = 1'b0;
          rep_d    = e_q;
          rep_ok_d = 1'b1;
          case (in_req_i.action)
            wllf_pkg::ACT_UPDATE, wllf_pkg::ACT_FLIP: begin
              state_d = (32'(in_req_i.site) < NSITES) ? ST_DIGIT : ST_TRD;
            end
            wllf_pkg::ACT_READ: begin
              rep_d    = EW'(in_req_i.bin);
              rep_ok_d = (32'(in_req_i.bin) < NLEVELS);
              state_d  = ST_TRD;
            end
            default: begin
              hist_only_d = 1'b1;
              clr_d       = '0;
              state_d     = ST_CLEAR;
            end
          endcase
        end
      end
      ST_DIGIT: begin
        coord_d[2'(3 - k_q[1:0])] = digit[DW-1:0];
        rem_d = quo;
        k_d   = 3'(k_q + 3'd1);
        if (k_q == 3'd3) begin
          k_d     = '0;
          state_d = ST_PRD;
        end
      end
      ST_PRD: begin
        // address k is out now, data of address k-1 is back
        if (k_q != 3'd0) begin
          negs_d = 3'(negs_q + 3'(pl_rdata_q));
          sbits_d[3'(k_q - 3'd1)] = pl_rdata_q;
        end
        k_d = 3'(k_q + 3'd1);
        if (k_q == 3'd6) begin
          k_d     = '0;
          state_d = ST_NB;
        end
      end
      ST_NB: begin
        if (req_q.action == wllf_pkg::ACT_FLIP) begin
          acc_d   = 1'b1;
          state_d = ST_FLIP;
        end else begin
          state_d = ST_LOGN;
        end
      end
      ST_LOGN: begin
        tb_addr = nb_q;
        state_d = ST_LOGO;
      end
      ST_LOGO: begin
        tb_addr = e_q;
        lnew_d  = lg_rdata_q;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (d_le0 || (req_q.neg_log_draw > dlog[LW-1:0])) begin
          acc_d   = 1'b1;
          state_d = ST_FLIP;
        end else begin
          inc_d   = 1'b1;
          state_d = ST_TRD;
        end
      end
      ST_FLIP: begin
        pl_we    = 1'b1;
        pl_wdata = ~sbits_q[k_q];
        k_d      = 3'(k_q + 3'd1);
        if (k_q == 3'd5) begin
          k_d     = '0;
          e_d     = nb_q;
          rep_d   = nb_q;
          inc_d   = (req_q.action == wllf_pkg::ACT_UPDATE);
          state_d = ST_TRD;
        end
      end
      ST_TRD: begin
        state_d = ST_TWR;
      end
      ST_TWR: begin
        if (!out_valid_q || out_ready_i) begin
          lg_we    = inc_q;
          vs_we    = inc_q;
          lg_wdata = lg_new;
          vs_wdata = vs_new;
          out_d.accepted     = acc_q;
          out_d.energy_index = 16'(e_q);
          out_d.log_density  = !rep_ok_q ? '0 : (inc_q ? lg_new : lg_rdata_q);
          out_d.visits       = !rep_ok_q ? '0 : (inc_q ? vs_new : vs_rdata_q);
          out_valid_d        = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      hist_only_q <= 1'b0;
      e_q         <= EW'(12*NSITES);
      linc_q      <= wllf_pkg::LOG_INC_RST;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hist_only_q <= hist_only_d;
      e_q         <= e_d;
      linc_q      <= linc_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    rem_q    <= rem_d;
    coord_q  <= coord_d;
    negs_q   <= negs_d;
    sbits_q  <= sbits_d;
    nb_q     <= (state_q == ST_NB) ? nb_d : nb_q;
    rep_q    <= rep_d;
    lnew_q   <= lnew_d;
    acc_q    <= acc_d;
    rep_ok_q <= rep_ok_d;
    inc_q    <= inc_d;
    out_q    <= out_d;
  end

  // plaquette sign memory
  always_ff @(posedge clk_i) begin
    if (pl_we) begin
      pl_mem[pl_addr] <= pl_wdata;
    end
    pl_rdata_q <= pl_mem[pl_addr];
  end

  // log-density and visit memories, shared address
  always_ff @(posedge clk_i) begin
    if (lg_we) begin
      lg_mem[tb_addr] <= lg_wdata;
    end
    lg_rdata_q <= lg_mem[tb_addr];
  end

  always_ff @(posedge clk_i) begin
    if (vs_we) begin
      vs_mem[tb_addr] <= vs_wdata;
    end
    vs_rdata_q <= vs_mem[tb_addr];
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

// File: rtl/wllf_checker.sv
// ----------------------------------------------------------------------------
// wllf_checker
// Port-level checks of the link-flip engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wllf_checker #(
  parameter int SIDE = 8
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               cfg_valid_i,
  input wire logic               cfg_ready_o,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire wllf_pkg::out_rsp_t out_rsp_o
);

  localparam int NLEVELS = 12*SIDE**4 + 1;

  // one request at a time
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  // reported energy stays in the bin range
  a_energy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_rsp_o.energy_index) < NLEVELS))
    else $error("energy index out of range");

  // configuration is always taken
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind wang_landau_link_flip wllf_checker #(.SIDE(SIDE)) u_wllf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

// File: tb/wllf_checker.sv
// ----------------------------------------------------------------------------
// wllf_scoreboard
// Watches the config, request and result channels of the link-flip engine.
// It keeps its own copy of the lattice and the tables, predicts each result
// and compares it field by field against what the engine returns.
// ----------------------------------------------------------------------------
`default_nettype none

module wllf_scoreboard #(
  parameter int SIDE = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  input  wire logic                       cfg_ready_i,
  input  wire logic [wllf_pkg::LOG_W-1:0] cfg_data_i,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_ready_i,
  input  wire wllf_pkg::in_req_t          in_req_i,
  input  wire logic                       out_valid_i,
  input  wire logic                       out_ready_i,
  input  wire wllf_pkg::out_rsp_t         out_rsp_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  localparam int NSITES  = SIDE * SIDE * SIDE * SIDE;
  localparam int NLEVELS = 12 * NSITES + 1;

  // mirror of the engine state
  bit                     plaq_neg[6*NSITES];
  int                     energy;
  longint unsigned        log_inc;
  longint unsigned        log_dens[int];
  longint unsigned        visit_cnt[int];
  wllf_pkg::out_rsp_t     rsp_fifo[$];

  assign pending_o = rsp_fifo.size();

  function automatic longint unsigned log_at(int b);
    return log_dens.exists(b) ? log_dens[b] : 64'd0;
  endfunction

  function automatic longint unsigned visits_at(int b);
    return visit_cnt.exists(b) ? visit_cnt[b] : 64'd0;
  endfunction

  // plane index for the pair of directions (xy,xz,xt,yz,yt,zt)
  function automatic int plane_for(int mu, int nu);
    int lo, hi;
    lo = (mu < nu) ? mu : nu;
    hi = (mu < nu) ? nu : mu;
    case (lo)
      0:       return hi - 1;
      1:       return hi + 1;
      default: return 5;
    endcase
  endfunction

  // periodic backward neighbor along one direction
  function automatic int back_site(int s, int dir);
    int stride, c;
    stride = 1;
    for (int k = dir; k < 3; k++) stride *= SIDE;
    c = (s / stride) % SIDE;
    return s - c * stride + ((c + SIDE - 1) % SIDE) * stride;
  endfunction

  // applies one request to the mirror and returns the expected result
  function automatic wllf_pkg::out_rsp_t apply_request(wllf_pkg::in_req_t r);
    int                 plaq[6];
    int                 n, neg, nb, site, dir, p, rep;
    longint             delta;
    longint unsigned    sum;
    bit                 acc, rep_ok;
    wllf_pkg::out_rsp_t o;
    acc    = 1'b0;
    rep    = energy;
    rep_ok = 1'b1;
    case (r.action)
      wllf_pkg::ACT_UPDATE, wllf_pkg::ACT_FLIP: begin
        site = r.site;
        dir  = r.direction;
        if (site < NSITES) begin
          n   = 0;
          neg = 0;
          for (int nu = 0; nu < 4; nu++) begin
            if (nu != dir) begin
              p         = plane_for(dir, nu);
              plaq[n]   = site * 6 + p;
              plaq[n+1] = back_site(site, nu) * 6 + p;
              n += 2;
            end
          end
          for (int k = 0; k < 6; k++) neg += plaq_neg[plaq[k]];
          nb = energy - 12 + 4 * neg;
          if (nb < 0) nb = 0;
          if (nb >= NLEVELS) nb = NLEVELS - 1;
          if (r.action == wllf_pkg::ACT_FLIP) begin
            acc = 1'b1;
          end else begin
            delta = longint'(log_at(nb)) - longint'(log_at(energy));
            acc   = (delta <= 0) || (longint'({16'd0, r.neg_log_draw}) > delta);
          end
          if (acc) begin
            for (int k = 0; k < 6; k++) plaq_neg[plaq[k]] ^= 1'b1;
            energy = nb;
          end
          if (r.action == wllf_pkg::ACT_UPDATE) begin
            sum              = log_at(energy) + log_inc;
            log_dens[energy] = (sum > wllf_pkg::LOG_MAX) ? wllf_pkg::LOG_MAX : sum;
            if (visits_at(energy) != wllf_pkg::VIS_MAX) begin
              visit_cnt[energy] = visits_at(energy) + 1;
            end
          end
        end
        rep = energy;
      end
      wllf_pkg::ACT_READ: begin
        rep    = r.bin;
        rep_ok = r.bin < NLEVELS;
      end
      default: visit_cnt.delete();
    endcase
    o.accepted     = acc;
    o.energy_index = energy[15:0];
    o.log_density  = rep_ok ? wllf_pkg::LOG_W'(log_at(rep)) : '0;
    o.visits       = rep_ok ? wllf_pkg::VIS_W'(visits_at(rep)) : '0;
    return o;
  endfunction

  // track config writes, requests and results
  always @(posedge clk_i or negedge rst_ni) begin
    wllf_pkg::out_rsp_t exp_rsp;
    if (!rst_ni) begin
      foreach (plaq_neg[i]) plaq_neg[i] = 1'b0;
      energy  = NLEVELS - 1;
      log_inc = wllf_pkg::LOG_INC_RST;
      log_dens.delete();
      visit_cnt.delete();
      rsp_fifo.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) log_inc = cfg_data_i;
      if (in_valid_i && in_ready_i) rsp_fifo = {rsp_fifo, apply_request(in_req_i)};
      if (out_valid_i && out_ready_i) begin
        if (rsp_fifo.size() == 0) begin
          $display("%0t: result with nothing outstanding: %p", $time, out_rsp_i);
          fail_count_o++;
        end else begin
          exp_rsp = rsp_fifo.pop_front();
          if (out_rsp_i.accepted !== exp_rsp.accepted) begin
            $display("%0t: accepted expected %0d got %0d", $time,
                     exp_rsp.accepted, out_rsp_i.accepted);
            fail_count_o++;
          end
          if (out_rsp_i.energy_index !== exp_rsp.energy_index) begin
            $display("%0t: energy_index expected %0d got %0d", $time,
                     exp_rsp.energy_index, out_rsp_i.energy_index);
            fail_count_o++;
          end
          if (out_rsp_i.log_density !== exp_rsp.log_density) begin
            $display("%0t: log_density expected %h got %h", $time,
                     exp_rsp.log_density, out_rsp_i.log_density);
            fail_count_o++;
          end
          if (out_rsp_i.visits !== exp_rsp.visits) begin
            $display("%0t: visits expected %0d got %0d", $time,
                     exp_rsp.visits, out_rsp_i.visits);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the link-flip engine. Directed requests hit the
// lattice corners, every action and the out-of-range bin reads, then random
// requests run in five phases under three idling mixes and several log increments.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic [wllf_pkg::LOG_W-1:0] cfg_data = '0;
  logic                       in_valid = 1'b0;
  wllf_pkg::in_req_t          in_req = '0;
  logic                       out_ready = 1'b0;
  logic                       cfg_ready, in_ready, out_valid;
  wllf_pkg::out_rsp_t         out_rsp;
  int                         fail_count, pending;
  int                         snd_idle, rcv_idle;
  bit                         hold_req = 1'b0;
  int                         hold_left = 0;
  int                         act_cnt[4] = '{0, 0, 0, 0};
  int                         site_pool[8];

  wang_landau_link_flip #(.SIDE(8)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_rsp_o(out_rsp)
  );

  wllf_scoreboard #(.SIDE(8)) u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_req_i(in_req),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_rsp_i(out_rsp),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #20000000;
    $display("[wang_landau_link_flip] ERROR");
    $finish;
  end

  // result side: random stalls plus an occasional long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  task automatic write_log_inc(logic [wllf_pkg::LOG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_request(wllf_pkg::in_req_t r);
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    act_cnt[r.action]++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic wllf_pkg::in_req_t make_req(logic [1:0] act, int site, int dir,
                                                 logic [wllf_pkg::LOG_W-1:0] draw,
                                                 int bin);
    wllf_pkg::in_req_t r;
    r.action       = act;
    r.site         = site[11:0];
    r.direction    = dir[1:0];
    r.neg_log_draw = draw;
    r.bin          = bin[15:0];
    return r;
  endfunction

  // random request: mostly updates on a small set of sites, rare clears
  function automatic wllf_pkg::in_req_t random_req();
    int                         pick, site, bin;
    logic [1:0]                 act;
    logic [wllf_pkg::LOG_W-1:0] draw;
    pick = $urandom_range(149);
    if (pick == 0)       act = wllf_pkg::ACT_CLEAR;
    else if (pick < 85)  act = wllf_pkg::ACT_UPDATE;
    else if (pick < 115) act = wllf_pkg::ACT_FLIP;
    else                 act = wllf_pkg::ACT_READ;
    site = ($urandom_range(9) < 7) ? site_pool[$urandom_range(7)] : $urandom_range(4095);
    case ($urandom_range(3))
      0:       draw = '0;
      1:       draw = wllf_pkg::LOG_MAX;
      2:       draw = wllf_pkg::LOG_W'($urandom_range(32'hFFFF_FFFF)) << $urandom_range(2);
      default: draw = wllf_pkg::LOG_W'({$urandom(), $urandom()});
    endcase
    case ($urandom_range(4))
      0:       bin = $urandom_range(65535);
      1:       bin = $urandom_range(48999);
      default: bin = $urandom_range(49000, 49152);
    endcase
    return make_req(act, site, $urandom_range(3), draw, bin);
  endfunction

  task automatic random_phase(int n, int snd, int rcv, bit with_hold);
    snd_idle = snd;
    rcv_idle = rcv;
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 3) hold_req = 1'b1;
      send_request(random_req());
    end
    drain();
  endtask

  initial begin
    snd_idle = 11;
    rcv_idle = 45;
    foreach (site_pool[i]) site_pool[i] = $urandom_range(4095);
    site_pool[0] = 0;
    site_pool[1] = 4095;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: corners, every action, out-of-range bins, default increment
    send_request(make_req(wllf_pkg::ACT_UPDATE, 0, 0, '0, 0));
    send_request(make_req(wllf_pkg::ACT_UPDATE, 0, 1, '0, 0));
    send_request(make_req(wllf_pkg::ACT_UPDATE, 0, 2, wllf_pkg::LOG_MAX, 0));
    send_request(make_req(wllf_pkg::ACT_UPDATE, 4095, 3, wllf_pkg::LOG_MAX, 0));
    send_request(make_req(wllf_pkg::ACT_FLIP, 0, 0, '0, 0));
    send_request(make_req(wllf_pkg::ACT_UPDATE, 0, 0, '0, 0));
    send_request(make_req(wllf_pkg::ACT_UPDATE, 0, 0, wllf_pkg::LOG_MAX, 0));
    send_request(make_req(wllf_pkg::ACT_FLIP, 4095, 3, wllf_pkg::LOG_MAX, 65535));
    send_request(make_req(wllf_pkg::ACT_FLIP, 4095, 3, '0, 0));
    send_request(make_req(wllf_pkg::ACT_READ, 0, 0, '0, 49152));
    send_request(make_req(wllf_pkg::ACT_READ, 0, 0, '0, 49128));
    send_request(make_req(wllf_pkg::ACT_READ, 0, 0, '0, 49153));
    send_request(make_req(wllf_pkg::ACT_READ, 4095, 3, wllf_pkg::LOG_MAX, 65535));
    send_request(make_req(wllf_pkg::ACT_READ, 0, 0, '0, 0));
    send_request(make_req(wllf_pkg::ACT_CLEAR, 0, 0, '0, 0));
    send_request(make_req(wllf_pkg::ACT_READ, 0, 0, '0, 49152));
    send_request(make_req(wllf_pkg::ACT_UPDATE, 2730, 2, 48'h0000_8000_0000, 21845));
    send_request(make_req(wllf_pkg::ACT_UPDATE, 1365, 1, 48'hAAAA_5555_AAAA, 43690));
    drain();

    // largest increment saturates quickly
    write_log_inc(wllf_pkg::LOG_MAX);
    random_phase(40, 11, 45, 1'b0);
    write_log_inc(48'h0000_0000_0001);
    random_phase(130, 11, 45, 1'b0);
    write_log_inc('0);
    random_phase(50, 45, 11, 1'b1);
    write_log_inc(wllf_pkg::LOG_W'({$urandom_range(65535), $urandom()} >>
                                   $urandom_range(20)));
    random_phase(100, 45, 11, 1'b0);
    write_log_inc(wllf_pkg::LOG_INC_RST);
    random_phase(120, 0, 0, 1'b0);

    repeat (50) @(posedge clk);
    $display("requests: %0d update, %0d forced flip, %0d read, %0d clear",
             act_cnt[wllf_pkg::ACT_UPDATE], act_cnt[wllf_pkg::ACT_FLIP],
             act_cnt[wllf_pkg::ACT_READ], act_cnt[wllf_pkg::ACT_CLEAR]);
    $display("increments from zero to full scale, three stall mixes, %0d mismatches",
             fail_count);
    if (fail_count == 0) begin
      $display("[wang_landau_link_flip] OK");
    end else begin
      $display("[wang_landau_link_flip] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
